// File: src/byte_ring_buffer_with_overwrite_defines.svh
// assertion macros for the byte ring buffer
`ifndef BYTE_RING_BUFFER_WITH_OVERWRITE_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_OVERWRITE_DEFINES_SVH

// same-cycle implication, checked on clk outside of reset
`define BRBUF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside of reset
`define BRBUF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/brbuf_pkg.sv
// shared types and constants for the byte ring buffer
package brbuf_pkg;

	localparam int unsigned DEPTH_DEFAULT = 1024;
	localparam int unsigned FIELD_W       = 10;

	typedef enum logic [1:0] {
		FUNC_WRITE     = 2'd0,
		FUNC_OVERWRITE = 2'd1,
		FUNC_READ      = 2'd2
	} func_t;

	typedef struct packed {
		func_t        func;
		logic [7:0]   data_byte;
		logic         end_of_request;
	} cmd_t;

	typedef struct packed {
		logic               accepted;
		logic [7:0]         read_byte;
		logic [FIELD_W-1:0] request_total;
		logic [FIELD_W-1:0] fill_level;
		logic               dropped_oldest;
	} rsp_t;

	// result of one operation, waiting for the store read data
	typedef struct packed {
		logic               accepted;
		logic               rd;
		logic [FIELD_W-1:0] request_total;
		logic [FIELD_W-1:0] fill_level;
		logic               dropped_oldest;
	} stage_t;

endpackage

// File: src/brbuf_stream_if.sv
// valid/ready stream channel with a typed payload
interface brbuf_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// File: src/brbuf_ram.sv
// generic single-port-write, registered-read RAM
module brbuf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: src/brbuf_ctrl.sv
// pointer, fill and request-count control for the byte ring buffer
module brbuf_ctrl #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  brbuf_pkg::cmd_t          cmd,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic                     rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	output brbuf_pkg::stage_t        res
);
	import brbuf_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [AW-1:0] wp_q, rp_q, cnt_q;
	logic [AW-1:0] wp_n, rp_n, cnt_n, cnt_inc, held, held_n;
	logic          full, empty, ok, do_wr, do_rd, drop;

	// occupancy of the store before this operation
	assign held  = wp_q - rp_q;
	assign full  = (held == {AW{1'b1}});
	assign empty = (held == {AW{1'b0}});

	// decode the operation
	always_comb begin
		ok    = 1'b0;
		do_wr = 1'b0;
		do_rd = 1'b0;
		drop  = 1'b0;
		case (cmd.func)
			FUNC_WRITE: begin
				do_wr = !full;
				ok    = !full;
			end
			FUNC_OVERWRITE: begin
				do_wr = 1'b1;
				drop  = full;
				ok    = 1'b1;
			end
			FUNC_READ: begin
				do_rd = !empty;
				ok    = !empty;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// next pointers and saturating request count
	always_comb begin
		wp_n    = do_wr ? wp_q + 1'b1 : wp_q;
		rp_n    = (do_rd || drop) ? rp_q + 1'b1 : rp_q;
		cnt_inc = (ok && (cnt_q != {AW{1'b1}})) ? cnt_q + 1'b1 : cnt_q;
		cnt_n   = cmd.end_of_request ? {AW{1'b0}} : cnt_inc;
		held_n  = wp_n - rp_n;
	end

	// store access for this operation
	assign wr_en   = fire && do_wr;
	assign wr_addr = wp_q;
	assign rd_en   = fire && do_rd;
	assign rd_addr = rp_q;

	// result fields, resized to the port widths
	always_comb begin
		res.accepted       = ok;
		res.rd             = do_rd;
		res.request_total  = FIELD_W'(cnt_inc);
		res.fill_level     = FIELD_W'(held_n);
		res.dropped_oldest = drop;
	end

	// state update on each command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			wp_q  <= wp_n;
			rp_q  <= rp_n;
			cnt_q <= cnt_n;
		end
	end

endmodule

// File: src/byte_ring_buffer_with_overwrite.sv
// top level of the byte ring buffer with overwrite
// throughput: one command per cycle while the response register is free or drains;
//   the pointer update and the store's registered read port form a single stage
//   ahead of the response register
// reset: arst_n clears pointers, request count and stage valids at once;
//   store contents are not cleared and need no clearing pass
`include "byte_ring_buffer_with_overwrite_defines.svh"

module byte_ring_buffer_with_overwrite #(
	parameter int unsigned DEPTH = brbuf_pkg::DEPTH_DEFAULT
) (
	input logic            clk,
	input logic            arst_n,
	brbuf_stream_if.sink   cmd,
	brbuf_stream_if.source rsp
);
	import brbuf_pkg::*;

	localparam int unsigned AW        = $clog2(DEPTH);
	localparam logic [FIELD_W-1:0] FILL_FULL = FIELD_W'(DEPTH - 1);

	cmd_t          cmd_data;
	logic          fire, adv;
	logic          ram_wr_en, ram_rd_en;
	logic [AW-1:0] ram_wr_addr, ram_rd_addr;
	logic [7:0]    ram_rd_data;
	stage_t        op_res;
	stage_t        info_s1;
	logic          valid_s1;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	assign cmd_data = cmd.payload;

	// handshake: the stage moves when the response register is free or drains
	assign adv       = !rsp_valid_q || rsp.ready;
	assign cmd.ready = !valid_s1 || adv;
	assign fire      = cmd.valid && cmd.ready;

	brbuf_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.cmd     (cmd_data),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.res     (op_res)
	);

	brbuf_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (cmd_data.data_byte),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (fire) begin
			info_s1 <= op_res;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// response payload, merging the store read data
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_q.accepted       <= info_s1.accepted;
			rsp_q.read_byte      <= info_s1.rd ? ram_rd_data : 8'h00;
			rsp_q.request_total  <= info_s1.request_total;
			rsp_q.fill_level     <= info_s1.fill_level;
			rsp_q.dropped_oldest <= info_s1.dropped_oldest;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// checks
	`BRBUF_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv,
		valid_s1 && $stable(info_s1), "stage 1 lost an item while stalled")
	`BRBUF_ASSERT_SAME(a_drop_full, rsp_valid_q && rsp_q.dropped_oldest,
		rsp_q.accepted && (rsp_q.fill_level == FILL_FULL), "drop without full store")
	`BRBUF_ASSERT_SAME(a_reject_clean, rsp_valid_q && !rsp_q.accepted,
		(rsp_q.read_byte == 8'h00) && !rsp_q.dropped_oldest, "rejected op carries data")
	`BRBUF_ASSERT_SAME(a_ram_on_fire, ram_rd_en || ram_wr_en, fire,
		"store access without a command transfer")

endmodule
